// ----- hdl/oast_pkg.sv -----
// ----------------------------------------------------------------------------
// oast_pkg
// Shared constants, types and codes of the ordered alarm slot table.
// ----------------------------------------------------------------------------
package oast_pkg;

  localparam int NUM_SLOTS     = 8;
  localparam int IDX_W         = $clog2(NUM_SLOTS);
  localparam int CNT_W         = $clog2(NUM_SLOTS + 1);
  localparam int SEQ_W         = 32;
  localparam int DAYS_W        = 7;
  localparam int DAYS_PER_WEEK = 7;
  localparam int DATA_W        = 18;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [DAYS_W-1:0] days_t;

  typedef enum logic [3:0] {
    FUNC_CLEAR   = 4'd0,
    FUNC_ADD     = 4'd1,
    FUNC_FIRST   = 4'd2,
    FUNC_NEXT    = 4'd3,
    FUNC_PREV    = 4'd4,
    FUNC_COUNT   = 4'd5,
    FUNC_DISABLE = 4'd6,
    FUNC_BACKUP  = 4'd7,
    FUNC_RESTORE = 4'd8,
    FUNC_MATCH   = 4'd9
  } func_t;

  // Result of comparing one stored sequence against the two running bounds.
  typedef struct packed {
    logic zero;
    logic gt_cur;
    logic lt_cur;
    logic gt_best;
    logic lt_best;
  } cmp_t;

  // Write request to the sequence bank.
  typedef struct packed {
    logic clr_all;
    logic we;
    idx_t idx;
    seq_t data;
  } seq_wr_t;

endpackage

// ----- hdl/oast_in_if.sv -----
// ----------------------------------------------------------------------------
// oast_in_if
// Request channel of the alarm slot table: one operation word per handshake.
// ----------------------------------------------------------------------------
interface oast_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] func;
  logic [2:0] slot;
  logic [6:0] day_mask;
  logic [3:0] hour_in;
  logic [5:0] minute_in;
  logic [5:0] second_in;
  logic       pm_in;
  logic       turn_right;
  logic [2:0] weekday;

  modport source (
    output valid, func, slot, day_mask, hour_in, minute_in, second_in, pm_in,
           turn_right, weekday,
    input  ready
  );
  modport sink (
    input  valid, func, slot, day_mask, hour_in, minute_in, second_in, pm_in,
           turn_right, weekday,
    output ready
  );
endinterface

// ----- hdl/oast_out_if.sv -----
// ----------------------------------------------------------------------------
// oast_out_if
// Result channel of the alarm slot table: one result word per handshake.
// ----------------------------------------------------------------------------
interface oast_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [2:0] slot_out;
  logic [6:0] days_out;
  logic [3:0] hour_out;
  logic [5:0] minute_out;
  logic [5:0] second_out;
  logic       pm_out;
  logic       right_out;
  logic [3:0] used_count;

  modport source (
    output valid, found, slot_out, days_out, hour_out, minute_out, second_out,
           pm_out, right_out, used_count,
    input  ready
  );
  modport sink (
    input  valid, found, slot_out, days_out, hour_out, minute_out, second_out,
           pm_out, right_out, used_count,
    output ready
  );
endinterface

// ----- hdl/oast_ram.sv -----
// ----------------------------------------------------------------------------
// oast_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module oast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/oast_seq_cmp.sv -----
// ----------------------------------------------------------------------------
// oast_seq_cmp
// Shared sequence comparator used by every scan of the slot table.
// ----------------------------------------------------------------------------
module oast_seq_cmp (
  input  oast_pkg::seq_t seq,
  input  oast_pkg::seq_t cur,
  input  oast_pkg::seq_t best,
  output oast_pkg::cmp_t res
);

  always_comb begin
    res.zero    = (seq == '0);
    res.gt_cur  = (seq > cur);
    res.lt_cur  = (seq < cur);
    res.gt_best = (seq > best);
    res.lt_best = (seq < best);
  end

endmodule

// ----- hdl/oast_seq_bank.sv -----
// ----------------------------------------------------------------------------
// oast_seq_bank
// Sequence numbers of all slots with a running count of used slots.
// ----------------------------------------------------------------------------
module oast_seq_bank (
  input  logic              clk,
  input  logic              rst_n,
  input  oast_pkg::idx_t    rd_idx,
  output oast_pkg::seq_t    rd_seq,
  input  oast_pkg::seq_wr_t wr,
  output oast_pkg::cnt_t    count
);

  oast_pkg::seq_t seq_r [oast_pkg::NUM_SLOTS];
  oast_pkg::cnt_t count_r;
  oast_pkg::cnt_t count_nxt;
  logic [oast_pkg::NUM_SLOTS-1:0] used_vec;
  logic old_used;
  logic new_used;

  assign rd_seq   = seq_r[rd_idx];
  assign old_used = (seq_r[wr.idx] != '0);
  assign new_used = (wr.data != '0);

  always_comb begin
    for (int i = 0; i < oast_pkg::NUM_SLOTS; i++) begin
      used_vec[i] = (seq_r[i] != '0);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (wr.clr_all) begin
      count_nxt = '0;
    end else if (wr.we && new_used && !old_used) begin
      count_nxt = count_r + oast_pkg::cnt_t'(1);
    end else if (wr.we && !new_used && old_used) begin
      count_nxt = count_r - oast_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < oast_pkg::NUM_SLOTS; i++) begin
        seq_r[i] <= '0;
      end
      count_r <= '0;
    end else begin
      if (wr.clr_all) begin
        for (int i = 0; i < oast_pkg::NUM_SLOTS; i++) begin
          seq_r[i] <= '0;
        end
      end else if (wr.we) begin
        seq_r[wr.idx] <= wr.data;
      end
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == oast_pkg::cnt_t'($countones(used_vec)))
    else $error("Used count disagrees with the sequence bank.");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    wr.clr_all |=> (count_r == '0) && (used_vec == '0))
    else $error("Clear did not free every slot.");

endmodule

// ----- hdl/ordered_alarm_slot_table_core.sv -----
// ----------------------------------------------------------------------------
// ordered_alarm_slot_table_core
// Alarm slot table ordered by sequence number, with a navigation cursor.
//
//   Channel   Direction  Handshake         Word
//   in_word   input      valid / ready     one operation and its arguments
//   out_word  output     valid / ready     one result per operation
//
// Add, first, next and prev scan the sequence bank and, when they find a slot,
// fetch its entry as well; disable scans the bank and fetches nothing. Match
// fetches the entry unless the weekday is out of range; the rest fetch nothing.
// The scan walks the sequence bank through the shared comparator, one slot
// per cycle; one word is worked on at a time.
// Reset frees every slot and clears the cursor and its backup copy.
// A result waits in the output register while the next word is accepted;
// the block stalls before writing a new result until that register is free.
// ----------------------------------------------------------------------------
module ordered_alarm_slot_table_core (
  input  logic       clk,
  input  logic       rst_n,
  oast_in_if.sink    in_word,
  oast_out_if.source out_word
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_FIN   = 6'b001000,
    ST_FETCH = 6'b010000,
    ST_LOAD  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  oast_pkg::func_t func_r;
  logic [2:0]      slot_r;
  logic [6:0]      days_in_r;
  logic [3:0]      hour_in_r;
  logic [5:0]      minute_in_r;
  logic [5:0]      second_in_r;
  logic            pm_in_r;
  logic            right_in_r;
  logic [2:0]      weekday_r;

  oast_pkg::idx_t cursor_r, cursor_nxt;
  oast_pkg::idx_t saved_r, saved_nxt;
  oast_pkg::seq_t cur_seq_r, cur_seq_nxt;
  oast_pkg::seq_t best_seq_r, best_seq_nxt;
  oast_pkg::idx_t best_idx_r, best_idx_nxt;
  logic           have_r, have_nxt;
  oast_pkg::idx_t free_idx_r, free_idx_nxt;
  logic           have_free_r, have_free_nxt;
  oast_pkg::cnt_t cnt_r, cnt_nxt;
  oast_pkg::idx_t addr_r, addr_nxt;
  logic           found_r, found_nxt;
  logic [2:0]     sout_r, sout_nxt;
  logic           match_ok_r, match_ok_nxt;

  logic       out_valid_r;
  logic       out_found_r;
  logic [2:0] out_slot_r;
  logic [6:0] out_days_r;
  logic [3:0] out_hour_r;
  logic [5:0] out_minute_r;
  logic [5:0] out_second_r;
  logic       out_pm_r;
  logic       out_right_r;
  logic [3:0] out_count_r;

  logic              accept;
  logic              is_disable;
  logic              slot_ok;
  oast_pkg::idx_t    slot_idx;
  oast_pkg::idx_t    scan_idx;
  logic              scan_act;
  logic              scan_last;
  oast_pkg::idx_t    bank_rd_idx;
  oast_pkg::seq_t    bank_rd_seq;
  oast_pkg::seq_wr_t bank_wr;
  oast_pkg::cnt_t    bank_count;
  oast_pkg::cmp_t    cmp;
  logic              load_go;
  logic              match_hit;
  logic              result_found;

  logic                        days_we;
  oast_pkg::idx_t              days_waddr;
  oast_pkg::days_t             days_wdata;
  oast_pkg::days_t             days_rd;
  logic                        data_we;
  logic [oast_pkg::DATA_W-1:0] data_wdata;
  logic [oast_pkg::DATA_W-1:0] data_rd;
  oast_pkg::idx_t              ram_raddr;

  assign accept     = in_word.valid && in_word.ready;
  assign is_disable = (func_r == oast_pkg::FUNC_DISABLE);
  assign slot_ok    = (32'(slot_r) < 32'(oast_pkg::NUM_SLOTS));
  assign slot_idx   = oast_pkg::idx_t'(slot_r);
  assign scan_idx   = is_disable ? oast_pkg::idx_t'(cnt_r - oast_pkg::cnt_t'(1))
                                 : oast_pkg::idx_t'(cnt_r);
  assign scan_act   = !is_disable || (cnt_r != '0);
  assign scan_last  = is_disable ? (cnt_r == oast_pkg::cnt_t'(oast_pkg::NUM_SLOTS))
                                 : (cnt_r == oast_pkg::cnt_t'(oast_pkg::NUM_SLOTS - 1));
  assign load_go    = !out_valid_r || out_word.ready;

  always_comb begin
    case (state_r)
      ST_PREP: bank_rd_idx = cursor_r;
      ST_SCAN: bank_rd_idx = scan_idx;
      default: bank_rd_idx = addr_r;
    endcase
  end

  assign ram_raddr = (state_r == ST_SCAN) ? oast_pkg::idx_t'(cnt_r) : addr_r;

  oast_seq_bank u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (bank_rd_idx),
    .rd_seq (bank_rd_seq),
    .wr     (bank_wr),
    .count  (bank_count)
  );

  oast_seq_cmp u_cmp (
    .seq  (bank_rd_seq),
    .cur  (cur_seq_r),
    .best (best_seq_r),
    .res  (cmp)
  );

  oast_ram #(.WIDTH(oast_pkg::DAYS_W), .DEPTH(oast_pkg::NUM_SLOTS)) u_days_ram (
    .clk   (clk),
    .we    (days_we),
    .waddr (days_waddr),
    .wdata (days_wdata),
    .raddr (ram_raddr),
    .rdata (days_rd)
  );

  oast_ram #(.WIDTH(oast_pkg::DATA_W), .DEPTH(oast_pkg::NUM_SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (free_idx_r),
    .wdata (data_wdata),
    .raddr (ram_raddr),
    .rdata (data_rd)
  );

  assign data_wdata = {hour_in_r, minute_in_r, second_in_r, pm_in_r, right_in_r};

  assign match_hit = days_rd[weekday_r - 3'd1]
                  && (data_rd[1] == pm_in_r)
                  && (data_rd[17:14] == hour_in_r)
                  && (data_rd[13:8] == minute_in_r)
                  && (data_rd[7:2] == second_in_r);

  assign result_found = (func_r == oast_pkg::FUNC_MATCH) ? (match_ok_r && match_hit)
                                                         : found_r;

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    saved_nxt     = saved_r;
    cur_seq_nxt   = cur_seq_r;
    best_seq_nxt  = best_seq_r;
    best_idx_nxt  = best_idx_r;
    have_nxt      = have_r;
    free_idx_nxt  = free_idx_r;
    have_free_nxt = have_free_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    found_nxt     = found_r;
    sout_nxt      = sout_r;
    match_ok_nxt  = match_ok_r;
    bank_wr       = '0;
    days_we       = 1'b0;
    days_waddr    = free_idx_r;
    days_wdata    = days_in_r;
    data_we       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_PREP;
        end
      end

      ST_PREP: begin
        cur_seq_nxt   = bank_rd_seq;
        best_seq_nxt  = '0;
        best_idx_nxt  = '0;
        have_nxt      = 1'b0;
        free_idx_nxt  = '0;
        have_free_nxt = 1'b0;
        cnt_nxt       = '0;
        found_nxt     = 1'b0;
        match_ok_nxt  = 1'b0;
        sout_nxt      = 3'(cursor_r);
        state_nxt     = ST_LOAD;
        case (func_r)
          oast_pkg::FUNC_CLEAR: begin
            bank_wr.clr_all = 1'b1;
          end
          oast_pkg::FUNC_ADD,
          oast_pkg::FUNC_FIRST,
          oast_pkg::FUNC_NEXT,
          oast_pkg::FUNC_PREV: begin
            state_nxt = ST_SCAN;
          end
          oast_pkg::FUNC_DISABLE: begin
            if (slot_ok) begin
              days_we    = 1'b1;
              days_waddr = slot_idx;
              days_wdata = '0;
              state_nxt  = ST_SCAN;
            end
          end
          oast_pkg::FUNC_BACKUP: begin
            saved_nxt = cursor_r;
          end
          oast_pkg::FUNC_RESTORE: begin
            cursor_nxt = saved_r;
            sout_nxt   = 3'(saved_r);
          end
          oast_pkg::FUNC_MATCH: begin
            sout_nxt = slot_r;
            if (slot_ok && (weekday_r >= 3'd1)
                && (32'(weekday_r) <= 32'(oast_pkg::DAYS_PER_WEEK))) begin
              match_ok_nxt = 1'b1;
              addr_nxt     = slot_idx;
              state_nxt    = ST_FETCH;
            end
          end
          default: begin
          end
        endcase
      end

      ST_SCAN: begin
        cnt_nxt = cnt_r + oast_pkg::cnt_t'(1);
        if (scan_last) begin
          state_nxt = ST_FIN;
        end
        if (scan_act) begin
          case (func_r)
            oast_pkg::FUNC_ADD: begin
              if (!cmp.zero) begin
                if (cmp.gt_best) begin
                  best_seq_nxt = bank_rd_seq;
                end
              end else if (!have_free_r) begin
                have_free_nxt = 1'b1;
                free_idx_nxt  = scan_idx;
              end
            end
            oast_pkg::FUNC_FIRST: begin
              if (!cmp.zero && (!have_r || cmp.lt_best)) begin
                best_seq_nxt = bank_rd_seq;
                best_idx_nxt = scan_idx;
                have_nxt     = 1'b1;
              end
            end
            oast_pkg::FUNC_NEXT: begin
              if ((scan_idx != cursor_r) && !cmp.zero && cmp.gt_cur
                  && (!have_r || cmp.lt_best)) begin
                best_seq_nxt = bank_rd_seq;
                best_idx_nxt = scan_idx;
                have_nxt     = 1'b1;
              end
            end
            oast_pkg::FUNC_PREV: begin
              if ((scan_idx != cursor_r) && !cmp.zero && cmp.lt_cur
                  && (!have_r || cmp.gt_best)) begin
                best_seq_nxt = bank_rd_seq;
                best_idx_nxt = scan_idx;
                have_nxt     = 1'b1;
              end
            end
            oast_pkg::FUNC_DISABLE: begin
              if (!cmp.zero && (days_rd == '0)) begin
                bank_wr.we   = 1'b1;
                bank_wr.idx  = scan_idx;
                bank_wr.data = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FIN: begin
        state_nxt = ST_LOAD;
        case (func_r)
          oast_pkg::FUNC_ADD: begin
            if (have_free_r && (best_seq_r != '1)) begin
              bank_wr.we   = 1'b1;
              bank_wr.idx  = free_idx_r;
              bank_wr.data = best_seq_r + oast_pkg::seq_t'(1);
              days_we      = 1'b1;
              data_we      = 1'b1;
              found_nxt    = 1'b1;
              sout_nxt     = 3'(free_idx_r);
              addr_nxt     = free_idx_r;
              state_nxt    = ST_FETCH;
            end
          end
          oast_pkg::FUNC_FIRST,
          oast_pkg::FUNC_NEXT,
          oast_pkg::FUNC_PREV: begin
            if (have_r) begin
              cursor_nxt = best_idx_r;
              found_nxt  = 1'b1;
              sout_nxt   = 3'(best_idx_r);
              addr_nxt   = best_idx_r;
              state_nxt  = ST_FETCH;
            end
          end
          default: begin
          end
        endcase
      end

      ST_FETCH: begin
        state_nxt = ST_LOAD;
      end

      ST_LOAD: begin
        if (load_go) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      saved_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      saved_r  <= saved_nxt;
      if ((state_r == ST_LOAD) && load_go) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r      <= oast_pkg::func_t'(in_word.func);
      slot_r      <= in_word.slot;
      days_in_r   <= in_word.day_mask;
      hour_in_r   <= in_word.hour_in;
      minute_in_r <= in_word.minute_in;
      second_in_r <= in_word.second_in;
      pm_in_r     <= in_word.pm_in;
      right_in_r  <= in_word.turn_right;
      weekday_r   <= in_word.weekday;
    end
    cur_seq_r   <= cur_seq_nxt;
    best_seq_r  <= best_seq_nxt;
    best_idx_r  <= best_idx_nxt;
    have_r      <= have_nxt;
    free_idx_r  <= free_idx_nxt;
    have_free_r <= have_free_nxt;
    cnt_r       <= cnt_nxt;
    addr_r      <= addr_nxt;
    found_r     <= found_nxt;
    sout_r      <= sout_nxt;
    match_ok_r  <= match_ok_nxt;
    if ((state_r == ST_LOAD) && load_go) begin
      out_found_r  <= result_found;
      out_slot_r   <= sout_r;
      out_days_r   <= result_found ? days_rd : 7'd0;
      out_hour_r   <= result_found ? data_rd[17:14] : 4'd0;
      out_minute_r <= result_found ? data_rd[13:8] : 6'd0;
      out_second_r <= result_found ? data_rd[7:2] : 6'd0;
      out_pm_r     <= result_found ? data_rd[1] : 1'b0;
      out_right_r  <= result_found ? data_rd[0] : 1'b0;
      out_count_r  <= 4'(bank_count);
    end
  end

  assign in_word.ready       = (state_r == ST_IDLE);
  assign out_word.valid      = out_valid_r;
  assign out_word.found      = out_found_r;
  assign out_word.slot_out   = out_slot_r;
  assign out_word.days_out   = out_days_r;
  assign out_word.hour_out   = out_hour_r;
  assign out_word.minute_out = out_minute_r;
  assign out_word.second_out = out_second_r;
  assign out_word.pm_out     = out_pm_r;
  assign out_word.right_out  = out_right_r;
  assign out_word.used_count = out_count_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_word.ready)
    else $error("A new word was taken while an operation was in progress.");

  a_miss_has_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_days_r == '0) && (out_hour_r == '0)
      && (out_minute_r == '0) && (out_second_r == '0) && !out_pm_r && !out_right_r)
    else $error("Entry fields are set on a result that found nothing.");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_count_r) <= 32'(oast_pkg::NUM_SLOTS)))
    else $error("Used count exceeds the number of slots.");

  a_load_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_LOAD) && !load_go) |=> (state_r == ST_LOAD))
    else $error("A result was dropped while the output register was full.");

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ordered alarm slot table core. Each request word
// is run through a behavioral model of the table when it is generated. The
// predicted result joins the queue of awaited results once the core accepts
// the word. A directed opening covers empty, full and edge cases, and a long
// random phase follows. Both channels see bursts, gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS    = 950;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          SETTLE_CYCLES   = 40;
  localparam logic [3:0]  FUNC_UNUSED_LO  = 4'd10;
  localparam logic [3:0]  FUNC_UNUSED_HI  = 4'd15;

  typedef struct {
    logic [3:0]      func;
    logic [2:0]      slot;
    oast_pkg::days_t day_mask;
    logic [3:0]      hour;
    logic [5:0]      minute;
    logic [5:0]      second;
    logic            pm;
    logic            right;
    logic [2:0]      weekday;
  } alarm_req_t;

  typedef struct {
    logic            found;
    logic [2:0]      slot;
    oast_pkg::days_t days;
    logic [3:0]      hour;
    logic [5:0]      minute;
    logic [5:0]      second;
    logic            pm;
    logic            right;
    logic [3:0]      used;
  } alarm_resp_t;

  typedef struct {
    alarm_req_t  req;
    alarm_resp_t resp;
    bit          drain_first;
  } pending_t;

  logic clk;
  logic rst_n;

  oast_in_if  req_bus ();
  oast_out_if res_bus ();

  ordered_alarm_slot_table_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (req_bus),
    .out_word (res_bus)
  );

  // Model of the alarm table.
  oast_pkg::seq_t  tbl_seq     [oast_pkg::NUM_SLOTS] = '{default: '0};
  oast_pkg::days_t tbl_days    [oast_pkg::NUM_SLOTS] = '{default: '0};
  logic [3:0]      tbl_hour    [oast_pkg::NUM_SLOTS] = '{default: '0};
  logic [5:0]      tbl_minute  [oast_pkg::NUM_SLOTS] = '{default: '0};
  logic [5:0]      tbl_second  [oast_pkg::NUM_SLOTS] = '{default: '0};
  logic            tbl_pm      [oast_pkg::NUM_SLOTS] = '{default: '0};
  logic            tbl_right   [oast_pkg::NUM_SLOTS] = '{default: '0};
  bit              tbl_written [oast_pkg::NUM_SLOTS] = '{default: 0};
  oast_pkg::idx_t  tbl_cursor  = '0;
  oast_pkg::idx_t  tbl_saved   = '0;

  pending_t    pend_q[$];
  alarm_resp_t awaited_q[$];

  int fail_count  = 0;
  int cycle_count = 0;
  bit req_taken   = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int ready_mode  = 0;
  int ready_left  = 0;
  int ready_phase = 0;

  function automatic alarm_resp_t apply_alarm_op(input alarm_req_t r);
    alarm_resp_t    res;
    logic           found;
    oast_pkg::idx_t sout;
    oast_pkg::seq_t hi;
    oast_pkg::seq_t cur_seq;
    bit             have;
    bit             up;
    int             best;
    int             cnt;
    res   = '{default: '0};
    found = 1'b0;
    sout  = tbl_cursor;
    have  = 0;
    best  = 0;
    case (r.func)
      oast_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < oast_pkg::NUM_SLOTS; i++) tbl_seq[i] = '0;
      end
      oast_pkg::FUNC_ADD: begin
        hi = '0;
        for (int i = 0; i < oast_pkg::NUM_SLOTS; i++) begin
          if (tbl_seq[i] != '0) begin
            if (tbl_seq[i] > hi) hi = tbl_seq[i];
          end else if (!have) begin
            have = 1;
            best = i;
          end
        end
        if (have && hi != '1) begin
          tbl_seq[best]     = hi + oast_pkg::seq_t'(1);
          tbl_days[best]    = r.day_mask;
          tbl_hour[best]    = r.hour;
          tbl_minute[best]  = r.minute;
          tbl_second[best]  = r.second;
          tbl_pm[best]      = r.pm;
          tbl_right[best]   = r.right;
          tbl_written[best] = 1;
          found = 1'b1;
          sout  = oast_pkg::idx_t'(best);
        end
      end
      oast_pkg::FUNC_FIRST: begin
        for (int i = 0; i < oast_pkg::NUM_SLOTS; i++) begin
          if (tbl_seq[i] != '0 && (!have || tbl_seq[i] < tbl_seq[best])) begin
            best = i;
            have = 1;
          end
        end
        if (have) begin
          tbl_cursor = oast_pkg::idx_t'(best);
          found = 1'b1;
        end
        sout = tbl_cursor;
      end
      oast_pkg::FUNC_NEXT, oast_pkg::FUNC_PREV: begin
        up      = (r.func == oast_pkg::FUNC_NEXT);
        cur_seq = tbl_seq[tbl_cursor];
        best    = int'(tbl_cursor);
        for (int i = 0; i < oast_pkg::NUM_SLOTS; i++) begin
          if (i != int'(tbl_cursor) && tbl_seq[i] != '0 &&
              (up ? (tbl_seq[i] > cur_seq) : (tbl_seq[i] < cur_seq))) begin
            if (!have || (up ? (tbl_seq[i] < tbl_seq[best]) : (tbl_seq[i] > tbl_seq[best])))
            begin
              best = i;
              have = 1;
            end
          end
        end
        tbl_cursor = oast_pkg::idx_t'(best);
        found = have;
        sout  = tbl_cursor;
      end
      oast_pkg::FUNC_DISABLE: begin
        tbl_days[r.slot] = '0;
        for (int i = 0; i < oast_pkg::NUM_SLOTS; i++)
          if (tbl_seq[i] != '0 && tbl_days[i] == '0) tbl_seq[i] = '0;
      end
      oast_pkg::FUNC_BACKUP: tbl_saved = tbl_cursor;
      oast_pkg::FUNC_RESTORE: begin
        tbl_cursor = tbl_saved;
        sout = tbl_cursor;
      end
      oast_pkg::FUNC_MATCH: begin
        sout = r.slot;
        if (r.weekday >= 3'd1 && 32'(r.weekday) <= 32'(oast_pkg::DAYS_PER_WEEK))
          found = tbl_days[r.slot][r.weekday - 3'd1] && tbl_pm[r.slot] == r.pm &&
                  tbl_hour[r.slot] == r.hour && tbl_minute[r.slot] == r.minute &&
                  tbl_second[r.slot] == r.second;
      end
      default: ;
    endcase
    res.found = found;
    res.slot  = sout;
    if (found) begin
      res.days   = tbl_days[sout];
      res.hour   = tbl_hour[sout];
      res.minute = tbl_minute[sout];
      res.second = tbl_second[sout];
      res.pm     = tbl_pm[sout];
      res.right  = tbl_right[sout];
    end
    cnt = 0;
    for (int i = 0; i < oast_pkg::NUM_SLOTS; i++) if (tbl_seq[i] != '0) cnt++;
    res.used = cnt[3:0];
    return res;
  endfunction

  // Random content in every field but the function; mostly within the legal clock ranges.
  function automatic alarm_req_t rand_req(input logic [3:0] f);
    alarm_req_t r;
    r.func     = f;
    r.slot     = 3'($urandom);
    r.day_mask = 7'($urandom);
    r.pm       = 1'($urandom);
    r.right    = 1'($urandom);
    if ($urandom_range(0, 7) != 0) begin
      r.hour    = 4'($urandom_range(1, 12));
      r.minute  = 6'($urandom_range(0, 59));
      r.second  = 6'($urandom_range(0, 59));
      r.weekday = 3'($urandom_range(1, 7));
    end else begin
      r.hour    = 4'($urandom);
      r.minute  = 6'($urandom);
      r.second  = 6'($urandom);
      r.weekday = 3'($urandom);
    end
    return r;
  endfunction

  task automatic queue_req(input alarm_req_t r, input bit drain);
    pending_t p;
    p.req         = r;
    p.resp        = apply_alarm_op(r);
    p.drain_first = drain;
    pend_q.push_back(p);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.func       = '0;
    req_bus.slot       = '0;
    req_bus.day_mask   = '0;
    req_bus.hour_in    = '0;
    req_bus.minute_in  = '0;
    req_bus.second_in  = '0;
    req_bus.pm_in      = 1'b0;
    req_bus.turn_right = 1'b0;
    req_bus.weekday    = '0;
    res_bus.ready      = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver: bursts of words with gaps, holding each word until taken.
  always @(negedge clk) begin : drive_requests
    pending_t p;
    if (rst_n && (!req_bus.valid || req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        req_bus.valid <= 1'b0;
      end else if (pend_q.size() == 0 || (pend_q[0].drain_first && awaited_q.size() != 0)) begin
        req_bus.valid <= 1'b0;
      end else begin
        p = pend_q[0];
        req_bus.valid      <= 1'b1;
        req_bus.func       <= p.req.func;
        req_bus.slot       <= p.req.slot;
        req_bus.day_mask   <= p.req.day_mask;
        req_bus.hour_in    <= p.req.hour;
        req_bus.minute_in  <= p.req.minute;
        req_bus.second_in  <= p.req.second;
        req_bus.pm_in      <= p.req.pm;
        req_bus.turn_right <= p.req.right;
        req_bus.weekday    <= p.req.weekday;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Result receiver: ready follows one of several stall patterns at a time.
  always @(negedge clk) begin : drive_ready
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(20, 120);
    end
    ready_left--;
    ready_phase++;
    case (ready_mode)
      0:       res_bus.ready <= 1'b1;
      1:       res_bus.ready <= ($urandom_range(0, 3) != 0);
      2:       res_bus.ready <= ((ready_phase % 8) >= 3);
      default: res_bus.ready <= ((ready_phase % 6) == 0);
    endcase
  end

  always @(posedge clk) begin : watch_channels
    alarm_resp_t want;
    pending_t    head;
    cycle_count++;
    req_taken = 0;
    if (rst_n) begin
      if (res_bus.valid && res_bus.ready) begin
        if (awaited_q.size() == 0) begin
          $error("result word arrived with no result awaited");
          fail_count++;
        end else begin
          want = awaited_q.pop_front();
          check_field("found",      32'(want.found),  32'(res_bus.found));
          check_field("slot_out",   32'(want.slot),   32'(res_bus.slot_out));
          check_field("days_out",   32'(want.days),   32'(res_bus.days_out));
          check_field("hour_out",   32'(want.hour),   32'(res_bus.hour_out));
          check_field("minute_out", 32'(want.minute), 32'(res_bus.minute_out));
          check_field("second_out", 32'(want.second), 32'(res_bus.second_out));
          check_field("pm_out",     32'(want.pm),     32'(res_bus.pm_out));
          check_field("right_out",  32'(want.right),  32'(res_bus.right_out));
          check_field("used_count", 32'(want.used),   32'(res_bus.used_count));
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        head = pend_q.pop_front();
        awaited_q.push_back(head.resp);
        req_taken = 1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    alarm_req_t r;
    int         pick;
    int         nw;
    int         s;
    int         wd;
    int         cand [oast_pkg::NUM_SLOTS];

    // Operations on an empty table, with the cursor on a free slot.
    queue_req(rand_req(oast_pkg::FUNC_COUNT), 0);
    queue_req(rand_req(oast_pkg::FUNC_FIRST), 0);
    queue_req(rand_req(oast_pkg::FUNC_NEXT), 0);
    queue_req(rand_req(oast_pkg::FUNC_PREV), 0);
    // Extreme entries: every day at the last second, and an empty day mask.
    r = rand_req(oast_pkg::FUNC_ADD);
    r.day_mask = '1; r.hour = 4'd12; r.minute = 6'd59; r.second = 6'd59;
    r.pm = 1'b1; r.right = 1'b1;
    queue_req(r, 0);
    r = rand_req(oast_pkg::FUNC_ADD);
    r.day_mask = '0; r.hour = 4'd1; r.minute = '0; r.second = '0;
    r.pm = 1'b0; r.right = 1'b0;
    queue_req(r, 0);
    repeat (oast_pkg::NUM_SLOTS - 2) begin
      r = rand_req(oast_pkg::FUNC_ADD);
      r.day_mask[0] = 1'b1;
      queue_req(r, 0);
    end
    // The table is full, so this add is refused.
    queue_req(rand_req(oast_pkg::FUNC_ADD), 0);
    queue_req(rand_req(oast_pkg::FUNC_FIRST), 0);
    queue_req(rand_req(oast_pkg::FUNC_NEXT), 0);
    queue_req(rand_req(oast_pkg::FUNC_PREV), 0);
    queue_req(rand_req(oast_pkg::FUNC_BACKUP), 0);
    queue_req(rand_req(oast_pkg::FUNC_NEXT), 0);
    queue_req(rand_req(oast_pkg::FUNC_RESTORE), 0);
    r = rand_req(oast_pkg::FUNC_MATCH);
    r.slot = '0; r.hour = 4'd12; r.minute = 6'd59; r.second = 6'd59;
    r.pm = 1'b1; r.weekday = 3'd7;
    queue_req(r, 0);
    r.weekday = '0;
    queue_req(r, 0);
    r.weekday = 3'd1; r.pm = 1'b0;
    queue_req(r, 0);
    // Disabling one slot also drops the entry stored with no days.
    r = rand_req(oast_pkg::FUNC_DISABLE);
    r.slot = 3'd3;
    queue_req(r, 0);
    queue_req(rand_req(FUNC_UNUSED_LO), 0);
    queue_req(rand_req(FUNC_UNUSED_HI), 0);
    queue_req(rand_req(oast_pkg::FUNC_ADD), 0);
    queue_req(rand_req(oast_pkg::FUNC_CLEAR), 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) r = rand_req(oast_pkg::FUNC_CLEAR);
      else if (pick < 27) r = rand_req(oast_pkg::FUNC_ADD);
      else if (pick < 35) r = rand_req(oast_pkg::FUNC_FIRST);
      else if (pick < 50) r = rand_req(oast_pkg::FUNC_NEXT);
      else if (pick < 61) r = rand_req(oast_pkg::FUNC_PREV);
      else if (pick < 65) r = rand_req(oast_pkg::FUNC_COUNT);
      else if (pick < 74) r = rand_req(oast_pkg::FUNC_DISABLE);
      else if (pick < 78) r = rand_req(oast_pkg::FUNC_BACKUP);
      else if (pick < 82) r = rand_req(oast_pkg::FUNC_RESTORE);
      else if (pick < 97) begin
        // Matches only go to slots that an add has written.
        nw = 0;
        for (int i = 0; i < oast_pkg::NUM_SLOTS; i++)
          if (tbl_written[i]) begin
            cand[nw] = i;
            nw++;
          end
        if (nw == 0) begin
          r = rand_req(oast_pkg::FUNC_COUNT);
        end else begin
          s = cand[$urandom_range(0, nw - 1)];
          r = rand_req(oast_pkg::FUNC_MATCH);
          r.slot = 3'(s);
          if ($urandom_range(0, 3) != 0) begin
            r.hour   = tbl_hour[s];
            r.minute = tbl_minute[s];
            r.second = tbl_second[s];
            r.pm     = tbl_pm[s];
            if (tbl_days[s] != '0 && $urandom_range(0, 3) != 0) begin
              do wd = $urandom_range(1, 7); while (!tbl_days[s][wd - 1]);
              r.weekday = 3'(wd);
            end
            if ($urandom_range(0, 4) == 0) begin
              case ($urandom_range(0, 3))
                0:       r.weekday = '0;
                1:       r.pm = ~r.pm;
                2:       r.minute = r.minute + 6'd1;
                default: r.second = r.second ^ 6'd1;
              endcase
            end
          end
        end
      end else begin
        r = rand_req(4'($urandom_range(32'(FUNC_UNUSED_LO), 32'(FUNC_UNUSED_HI))));
      end
      queue_req(r, (n % 200) == 100);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || awaited_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
